// ===== rtl/core/depth_tested_pixel_writer_macros.svh =====
// Shared assertion macros for the pixel writer.
`ifndef DEPTH_TESTED_PIXEL_WRITER_MACROS_SVH
`define DEPTH_TESTED_PIXEL_WRITER_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define DTPW_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is held.
`define DTPW_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/dtpw_pkg.sv =====
package dtpw_pkg;

    localparam int MAX_WIDTH       = 512;
    localparam int MAX_HEIGHT      = 512;
    localparam int BYTES_PER_PIXEL = 3;
    localparam int STORE_SIZE      = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W          = $clog2(STORE_SIZE);

    localparam int OPCODE_W   = 3;
    localparam int COORD_W    = 12;
    localparam int DEPTH_W    = 32;
    localparam int CHAN_W     = 8;
    localparam int COLOR_W    = 3 * CHAN_W;
    localparam int STATUS_W   = 3;
    localparam int OFFSET_W   = 20;
    localparam int CFG_DIM_W  = 10;
    localparam int CFG_DATA_W = CFG_DIM_W;
    localparam int CFG_IDX_W  = 2;

    // stride = (width*3 + 3) & ~3, sized for the largest store width
    localparam int STRIDE_W = $clog2(MAX_WIDTH * BYTES_PER_PIXEL + 4);
    localparam int PROD_W   = STRIDE_W + COORD_W + 2;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [DEPTH_W-1:0] DEPTH_FAR = {1'b1, {(DEPTH_W-1){1'b0}}};

    localparam logic [OPCODE_W-1:0] OP_CLEAR_COLOR = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_CLEAR_DEPTH = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_WRITE       = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_ZTEST       = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_READ        = 3'd4;

    localparam logic [STATUS_W-1:0] ST_WRITTEN   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_REJECTED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_CLIPPED   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_READ_DONE = 3'd3;
    localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHECK_RANGE  = 2'd2;

    typedef enum logic [2:0] {
        K_CLEAR_COLOR,
        K_CLEAR_DEPTH,
        K_WRITE,
        K_ZTEST,
        K_READ,
        K_DROP
    } t_kind;

    typedef struct packed {
        t_kind                      kind;
        logic [ADDR_W-1:0]          addr;
        logic [OFFSET_W-1:0]        offset;
        logic signed [DEPTH_W-1:0]  depth;
        logic [COLOR_W-1:0]         rgb;
    } t_cmd;

    typedef struct packed {
        logic init_busy;
    } t_back_stat;

endpackage

// ===== rtl/core/dtpw_cmd_if.sv =====
interface dtpw_cmd_if import dtpw_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [OPCODE_W-1:0]        opcode;
    logic signed [COORD_W-1:0]  pos_x;
    logic signed [COORD_W-1:0]  pos_y;
    logic signed [DEPTH_W-1:0]  depth;
    logic [CHAN_W-1:0]          red_in;
    logic [CHAN_W-1:0]          green_in;
    logic [CHAN_W-1:0]          blue_in;

    modport source (
        output valid, opcode, pos_x, pos_y, depth, red_in, green_in, blue_in,
        input  ready
    );
    modport sink (
        input  valid, opcode, pos_x, pos_y, depth, red_in, green_in, blue_in,
        output ready
    );
endinterface

// ===== rtl/core/dtpw_res_if.sv =====
interface dtpw_res_if import dtpw_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [OFFSET_W-1:0]  byte_offset;
    logic [CHAN_W-1:0]    red_out;
    logic [CHAN_W-1:0]    green_out;
    logic [CHAN_W-1:0]    blue_out;

    modport source (
        output valid, status, byte_offset, red_out, green_out, blue_out,
        input  ready
    );
    modport sink (
        input  valid, status, byte_offset, red_out, green_out, blue_out,
        output ready
    );
endinterface

// ===== rtl/core/dtpw_front.sv =====
module dtpw_front import dtpw_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    dtpw_cmd_if.sink               i_cmd,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  t_back_stat             i_back_stat,
    output logic                   o_push_valid,
    input  logic                   i_push_ready,
    output t_cmd                   o_push_cmd
);

    logic [CFG_DIM_W-1:0] r_frame_width;
    logic [CFG_DIM_W-1:0] r_frame_height;
    logic                 r_check_range;
    logic                 r_valid;
    t_cmd                 r_cmd;
    t_cmd                 n_cmd;

    logic [COORD_W-1:0]  eff_w;
    logic [COORD_W-1:0]  eff_h;
    logic [COORD_W-1:0]  x_u;
    logic [COORD_W-1:0]  y_u;
    logic                in_frame;
    logic                in_store;
    logic                plain_ok;
    logic [STRIDE_W-1:0] stride_raw;
    logic [STRIDE_W-1:0] stride;
    logic [PROD_W-1:0]   off_full;
    logic                accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= CFG_DIM_W'(MAX_WIDTH);
            r_frame_height <= CFG_DIM_W'(MAX_HEIGHT);
            r_check_range  <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[CFG_DIM_W-1:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[CFG_DIM_W-1:0];
                CFG_CHECK_RANGE:  r_check_range  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // saturate the frame size to 1..store size
    always_comb begin
        if (r_frame_width == '0) begin
            eff_w = COORD_W'(1);
        end else if (COORD_W'(r_frame_width) > COORD_W'(MAX_WIDTH)) begin
            eff_w = COORD_W'(MAX_WIDTH);
        end else begin
            eff_w = COORD_W'(r_frame_width);
        end
        if (r_frame_height == '0) begin
            eff_h = COORD_W'(1);
        end else if (COORD_W'(r_frame_height) > COORD_W'(MAX_HEIGHT)) begin
            eff_h = COORD_W'(MAX_HEIGHT);
        end else begin
            eff_h = COORD_W'(r_frame_height);
        end
    end

    assign x_u = i_cmd.pos_x;
    assign y_u = i_cmd.pos_y;

    assign in_frame = !x_u[COORD_W-1] && !y_u[COORD_W-1] && (x_u < eff_w) && (y_u < eff_h);
    assign in_store = !x_u[COORD_W-1] && !y_u[COORD_W-1]
                   && (x_u < COORD_W'(MAX_WIDTH)) && (y_u < COORD_W'(MAX_HEIGHT));
    assign plain_ok = r_check_range ? in_frame : in_store;

    assign stride_raw = STRIDE_W'(eff_w) * STRIDE_W'(BYTES_PER_PIXEL) + STRIDE_W'(3);
    assign stride     = {stride_raw[STRIDE_W-1:2], 2'b00};
    assign off_full   = PROD_W'(stride) * PROD_W'(y_u)
                      + PROD_W'(x_u) * PROD_W'(BYTES_PER_PIXEL);

    always_comb begin
        n_cmd.addr   = ADDR_W'(y_u) * ADDR_W'(MAX_WIDTH) + ADDR_W'(x_u);
        n_cmd.offset = off_full[OFFSET_W-1:0];
        n_cmd.depth  = i_cmd.depth;
        n_cmd.rgb    = {i_cmd.red_in, i_cmd.green_in, i_cmd.blue_in};
        case (i_cmd.opcode)
            OP_CLEAR_COLOR: n_cmd.kind = K_CLEAR_COLOR;
            OP_CLEAR_DEPTH: n_cmd.kind = K_CLEAR_DEPTH;
            OP_WRITE:       n_cmd.kind = plain_ok ? K_WRITE : K_DROP;
            OP_ZTEST:       n_cmd.kind = in_frame ? K_ZTEST : K_DROP;
            OP_READ:        n_cmd.kind = plain_ok ? K_READ : K_DROP;
            default:        n_cmd.kind = K_DROP;
        endcase
    end

    // no requests while the depth store is swept after reset
    assign i_cmd.ready = (!r_valid || i_push_ready) && !i_back_stat.init_busy;
    assign accept      = i_cmd.valid && i_cmd.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_push_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

    assign o_push_valid = r_valid;
    assign o_push_cmd   = r_cmd;

endmodule

// ===== rtl/core/dtpw_queue.sv =====
module dtpw_queue import dtpw_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push_valid,
    output logic  o_push_ready,
    input  t_cmd  i_push_cmd,
    output logic  o_pop_valid,
    input  logic  i_pop_ready,
    output t_cmd  o_pop_cmd
);

`include "depth_tested_pixel_writer_macros.svh"

    t_cmd               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;
    logic               push;
    logic               pop;

    assign o_push_ready = (r_count != Q_CNT_W'(Q_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;
    assign o_pop_cmd    = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `DTPW_ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= Q_CNT_W'(Q_DEPTH))
    `DTPW_ASSERT_NEXT(a_push_count, i_clk, i_rst_n, push && !pop, r_count == $past(r_count) + 1'b1)
    `DTPW_ASSERT_NEXT(a_pop_count, i_clk, i_rst_n, pop && !push, r_count == $past(r_count) - 1'b1)

endmodule

// ===== rtl/core/dtpw_back.sv =====
module dtpw_back import dtpw_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_pop_valid,
    output logic        o_pop_ready,
    input  t_cmd        i_pop_cmd,
    output t_back_stat  o_stat,
    dtpw_res_if.source  o_res
);

`include "depth_tested_pixel_writer_macros.svh"

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_LOOK  = 4'b0010,
        S_CLEAR = 4'b0100,
        S_INIT  = 4'b1000
    } t_state;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [OFFSET_W-1:0] offset;
        logic [COLOR_W-1:0]  rgb;
    } t_res;

    logic [COLOR_W-1:0] mem_color [STORE_SIZE];
    logic [DEPTH_W-1:0] mem_depth [STORE_SIZE];

    t_state             r_state;
    t_state             n_state;
    logic [ADDR_W-1:0]  r_clr_idx;
    logic               r_clr_color;
    logic [COLOR_W-1:0] r_clr_rgb;
    t_cmd               r_cur;
    logic [COLOR_W-1:0] r_color_rd;
    logic [DEPTH_W-1:0] r_depth_rd;
    logic               r_out_valid;
    t_res               r_out;
    t_res               n_out;
    logic               n_out_load;

    logic               pop;
    logic               clr_last;
    logic               color_we;
    logic [ADDR_W-1:0]  color_waddr;
    logic [COLOR_W-1:0] color_wdata;
    logic               depth_we;
    logic [ADDR_W-1:0]  depth_waddr;
    logic [DEPTH_W-1:0] depth_wdata;
    logic               rd_en;
    logic               nearer;

    assign o_pop_ready = (r_state == S_IDLE) && !r_out_valid;
    assign pop         = i_pop_valid && o_pop_ready;
    assign clr_last    = (r_clr_idx == ADDR_W'(STORE_SIZE - 1));
    assign nearer      = $signed(r_cur.depth) > $signed(r_depth_rd);
    assign o_stat.init_busy = (r_state == S_INIT);

    always_comb begin
        n_state     = r_state;
        n_out_load  = 1'b0;
        n_out       = '{status: ST_CLIPPED, offset: '0, rgb: '0};
        color_we    = 1'b0;
        color_waddr = i_pop_cmd.addr;
        color_wdata = i_pop_cmd.rgb;
        depth_we    = 1'b0;
        depth_waddr = r_cur.addr;
        depth_wdata = r_cur.depth;
        rd_en       = 1'b0;
        case (r_state)
            S_INIT: begin
                depth_we    = 1'b1;
                depth_waddr = r_clr_idx;
                depth_wdata = DEPTH_FAR;
                if (clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_CLEAR: begin
                color_we    = r_clr_color;
                color_waddr = r_clr_idx;
                color_wdata = r_clr_rgb;
                depth_we    = !r_clr_color;
                depth_waddr = r_clr_idx;
                depth_wdata = DEPTH_FAR;
                if (clr_last) begin
                    n_state          = S_IDLE;
                    n_out_load       = 1'b1;
                    n_out.status     = ST_CLEARED;
                end
            end
            S_IDLE: begin
                if (pop) begin
                    case (i_pop_cmd.kind)
                        K_CLEAR_COLOR, K_CLEAR_DEPTH: begin
                            n_state = S_CLEAR;
                        end
                        K_WRITE: begin
                            color_we     = 1'b1;
                            n_out_load   = 1'b1;
                            n_out.status = ST_WRITTEN;
                            n_out.offset = i_pop_cmd.offset;
                        end
                        K_ZTEST, K_READ: begin
                            rd_en   = 1'b1;
                            n_state = S_LOOK;
                        end
                        default: begin
                            n_out_load = 1'b1;
                        end
                    endcase
                end
            end
            S_LOOK: begin
                n_state      = S_IDLE;
                n_out_load   = 1'b1;
                n_out.offset = r_cur.offset;
                color_waddr  = r_cur.addr;
                color_wdata  = r_cur.rgb;
                if (r_cur.kind == K_READ) begin
                    n_out.status = ST_READ_DONE;
                    n_out.rgb    = r_color_rd;
                end else if (nearer) begin
                    color_we     = 1'b1;
                    depth_we     = 1'b1;
                    n_out.status = ST_WRITTEN;
                end else begin
                    n_out.status = ST_REJECTED;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // stores: one write port each, registered read
    always_ff @(posedge i_clk) begin
        if (color_we) begin
            mem_color[color_waddr] <= color_wdata;
        end
        if (rd_en) begin
            r_color_rd <= mem_color[i_pop_cmd.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (depth_we) begin
            mem_depth[depth_waddr] <= depth_wdata;
        end
        if (rd_en) begin
            r_depth_rd <= mem_depth[i_pop_cmd.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_INIT || r_state == S_CLEAR) begin
                r_clr_idx <= clr_last ? '0 : r_clr_idx + 1'b1;
            end
            if (n_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_cur       <= i_pop_cmd;
            r_clr_color <= (i_pop_cmd.kind == K_CLEAR_COLOR);
            r_clr_rgb   <= i_pop_cmd.rgb;
        end
        if (n_out_load) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.status      = r_out.status;
    assign o_res.byte_offset = r_out.offset;
    assign o_res.red_out     = r_out.rgb[3*CHAN_W-1:2*CHAN_W];
    assign o_res.green_out   = r_out.rgb[2*CHAN_W-1:CHAN_W];
    assign o_res.blue_out    = r_out.rgb[CHAN_W-1:0];

    `DTPW_ASSERT_IMPL(a_out_free, i_clk, i_rst_n, n_out_load, !r_out_valid)
    `DTPW_ASSERT_NEXT(a_look_one_cycle, i_clk, i_rst_n, r_state == S_LOOK, r_state == S_IDLE)
    `DTPW_ASSERT_NEXT(a_init_once, i_clk, i_rst_n, r_state != S_INIT, r_state != S_INIT)
    `DTPW_ASSERT_IMPL(a_clr_idx_idle, i_clk, i_rst_n, r_state == S_IDLE, r_clr_idx == '0)

endmodule

// ===== rtl/core/depth_tested_pixel_writer.sv =====
// Raster output unit: 24-bit color store and signed depth store, one pixel per entry.
// i_cmd carries requests (clear color, clear depth, plain write, depth-tested write,
// read); o_res returns exactly one result per request, in order, with a status and
// the padded scanline byte offset. Both are valid/ready channels. Frame width,
// height and range checking are set through i_cfg_we/i_cfg_idx/i_cfg_data; the user
// must write them only while idle, which the block does not enforce. A request
// passes the front register, the queue and the back end to the result register;
// reads and depth tests also pass the registered store read in S_LOOK. The back
// end takes a new request only when idle with its single result register empty.
// A clear sweeps one entry per cycle over all STORE_SIZE (262144) entries, while later
// requests wait in the front register and the two-entry queue.
// Reset: the depth store is swept to the far value, all 262144 entries, with i_cmd.ready
// low; the color store holds nothing defined until cleared or written.
// A stalled receiver holds the result register; the queue and front register keep
// taking up to three more requests before i_cmd.ready drops.
module depth_tested_pixel_writer import dtpw_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    dtpw_cmd_if.sink               i_cmd,
    dtpw_res_if.source             o_res,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_back_stat back_stat;
    logic       push_valid;
    logic       push_ready;
    t_cmd       push_cmd;
    logic       pop_valid;
    logic       pop_ready;
    t_cmd       pop_cmd;

    dtpw_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (i_cmd),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_back_stat  (back_stat),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_cmd   (push_cmd)
    );

    dtpw_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_cmd   (push_cmd),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_cmd    (pop_cmd)
    );

    dtpw_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .o_pop_ready (pop_ready),
        .i_pop_cmd   (pop_cmd),
        .o_stat      (back_stat),
        .o_res       (o_res)
    );

endmodule
